// ===== rtl/tsrwa_pkg.sv =====
// Shared types, constants and command/status structs for the timed sample ring.
package tsrwa_pkg;

  localparam int Depth = 128;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = PtrW + 1;
  localparam int SeqW = 32;
  localparam int TimeW = 48;
  localparam int ValW = 28;
  localparam int WinW = 32;
  localparam int GmaxW = 8;
  localparam int SumW = ValW + CntW;
  localparam logic [TimeW-1:0] FreshMs = TimeW'(2000);
  localparam logic [TimeW-1:0] GraphMs = TimeW'(10000);
  localparam logic [GmaxW-1:0] MaxOut = GmaxW'(64);

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncReset = 2'd1;
  localparam logic [1:0] FuncAvg = 2'd2;
  localparam logic [1:0] FuncGraph = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FRESH_RD,
    ST_FRESH_CHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV,
    ST_EMIT_ONE,
    ST_GRAPH_SETUP,
    ST_GRAPH_RUN,
    ST_GRAPH_END
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic do_add;
    logic do_reset;
    logic rd_newest;
    logic latch_fresh;
    logic scan_step;
    logic div_start;
    logic graph_setup;
    logic emit_simple;
    logic emit_graph;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] func;
    logic scan_done;
    logic div_done;
    logic graph_empty;
    logic graph_done;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic accepted;
    logic [GmaxW-1:0] sample_count;
    logic [ValW-1:0] mean_value;
    logic [ValW-1:0] graph_value;
    logic item_valid;
    logic last;
  } result_t;

  typedef struct packed {
    logic [1:0] func;
    logic [SeqW-1:0] sequence_req;
    logic [TimeW-1:0] time_ms;
    logic [ValW-1:0] value_a;
    logic [ValW-1:0] value_b;
    logic field_select;
    logic [WinW-1:0] window_ms;
    logic [GmaxW-1:0] graph_max;
  } item_t;

endpackage

// ===== rtl/tsrwa_if.sv =====
// Valid/ready channel interface carrying one payload.
interface tsrwa_if #(type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tsrwa_ctrl.sv =====
// Sequencing state machine for the timed sample ring.
module tsrwa_ctrl import tsrwa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.func == FuncAdd || stat.func == FuncReset) begin
          state_next = ST_EMIT_ONE;
        end else begin
          state_next = ST_FRESH_RD;
        end
      end
      ST_FRESH_RD: state_next = ST_FRESH_CHK;
      ST_FRESH_CHK: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (stat.func == FuncAvg) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_GRAPH_SETUP;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_EMIT_ONE;
      end
      ST_EMIT_ONE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      ST_GRAPH_SETUP: begin
        if (stat.graph_empty) begin
          state_next = ST_EMIT_ONE;
        end else begin
          state_next = ST_GRAPH_RUN;
        end
      end
      ST_GRAPH_RUN: begin
        if (stat.graph_done) state_next = ST_GRAPH_END;
      end
      ST_GRAPH_END: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.do_add = (stat.func == FuncAdd);
        cmd.do_reset = (stat.func == FuncReset);
      end
      ST_FRESH_RD: cmd.rd_newest = 1'b1;
      ST_FRESH_CHK: cmd.latch_fresh = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_SCAN_END: cmd.div_start = (stat.func == FuncAvg);
      ST_DIV: ;
      ST_EMIT_ONE: cmd.emit_simple = !stat.out_busy;
      ST_GRAPH_SETUP: cmd.graph_setup = 1'b1;
      ST_GRAPH_RUN: cmd.emit_graph = 1'b1;
      ST_GRAPH_END: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tsrwa_dp.sv =====
// Datapath: sample memories, ring pointers, scan, divider and result register.
module tsrwa_dp import tsrwa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item_in,
  input  cmd_t    cmd,
  output stat_t   stat,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [TimeW-1:0] stamp_mem [Depth];
  logic [ValW-1:0] first_mem [Depth];
  logic [ValW-1:0] second_mem [Depth];

  item_t item;
  logic [PtrW-1:0] write_pointer;
  logic [CntW-1:0] fill_count;
  logic [SeqW-1:0] sequence_floor;
  logic accepted_flag;
  logic fresh;

  // Memory read port.
  logic [PtrW-1:0] rd_addr;
  logic rd_en;
  logic [TimeW-1:0] rd_stamp;
  logic [ValW-1:0] rd_first;
  logic [ValW-1:0] rd_second;

  // Scan state: issue index and the registered-data pipeline stage.
  logic [CntW-1:0] issue_idx;
  logic issue_active;
  logic data_vld;
  logic [SumW-1:0] sum;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] skip;
  logic graph_mode;

  // Divider.
  logic [SumW-1:0] div_rem;
  logic [SumW-1:0] div_quo;
  logic [$clog2(SumW+1)-1:0] div_steps;
  logic div_busy;

  // Graph limits.
  logic [CntW-1:0] limit;
  logic [CntW-1:0] emitted;

  logic out_busy;
  logic in_win_fresh;
  logic in_win_scan;
  logic [TimeW-1:0] win_w;
  logic [PtrW-1:0] base_slot;
  logic [CntW-1:0] elig_lim;
  logic [CntW-1:0] gmax_c;
  logic graph_done_r;
  logic [SumW:0] div_trial;
  logic scan_stall;
  logic graph_take;
  logic graph_emit;
  logic graph_fin;
  result_t out_next;

  function automatic logic in_window(input logic [TimeW-1:0] now,
                                     input logic [TimeW-1:0] at,
                                     input logic [TimeW-1:0] w);
    logic [TimeW-1:0] diff;
    diff = now - at;
    return (at != '0) && (at <= now) && (diff <= w);
  endfunction

  assign out_busy = out_valid && !out_ready;
  assign base_slot = write_pointer - fill_count[PtrW-1:0];
  assign win_w = graph_mode ? GraphMs : TimeW'(item.window_ms);
  assign in_win_fresh = in_window(item.time_ms, rd_stamp, FreshMs);
  assign in_win_scan = in_window(item.time_ms, rd_stamp, win_w);

  // While a graph result waits, the walk and the read port hold still.
  assign scan_stall = cmd.emit_graph && out_busy;
  assign graph_take = cmd.emit_graph && !out_busy && data_vld && in_win_scan && !graph_done_r;
  assign graph_emit = graph_take && (skip == '0);
  assign graph_fin = graph_emit && (emitted + CntW'(1) == limit);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = base_slot + issue_idx[PtrW-1:0];
    if (cmd.rd_newest) begin
      rd_en = 1'b1;
      rd_addr = write_pointer - PtrW'(1);
    end else if (issue_active && !scan_stall) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_stamp <= stamp_mem[rd_addr];
      rd_first <= first_mem[rd_addr];
      rd_second <= second_mem[rd_addr];
    end
    if (cmd.do_add && item.sequence_req > sequence_floor) begin
      stamp_mem[write_pointer] <= item.time_ms;
      first_mem[write_pointer] <= item.value_a;
      second_mem[write_pointer] <= item.value_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= item_in;
  end

  // Ring state and floor.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count <= '0;
      sequence_floor <= '0;
      accepted_flag <= 1'b0;
    end else begin
      if (cmd.load_item) accepted_flag <= 1'b0;
      if (cmd.do_add && item.sequence_req > sequence_floor) begin
        write_pointer <= write_pointer + PtrW'(1);
        if (fill_count != CntW'(Depth)) fill_count <= fill_count + CntW'(1);
        sequence_floor <= item.sequence_req;
        accepted_flag <= 1'b1;
      end
      if (cmd.do_reset) begin
        write_pointer <= '0;
        fill_count <= '0;
        if (item.sequence_req > sequence_floor) sequence_floor <= item.sequence_req;
      end
    end
  end

  assign gmax_c = (item.graph_max > GmaxW'(Depth)) ? CntW'(Depth)
                                                   : CntW'(item.graph_max);
  always_comb begin
    elig_lim = (cnt < gmax_c) ? cnt : gmax_c;
    if (elig_lim > CntW'(MaxOut)) elig_lim = CntW'(MaxOut);
  end

  assign div_trial = {div_rem[SumW-1:0], div_quo[SumW-1]} - {1'b0, {(SumW-CntW){1'b0}}, cnt};

  // Scan, graph and divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
      data_vld <= 1'b0;
      fresh <= 1'b0;
      div_busy <= 1'b0;
      graph_mode <= 1'b0;
      graph_done_r <= 1'b0;
    end else begin
      if (cmd.load_item) graph_mode <= (item_in.func == FuncGraph);
      if (cmd.latch_fresh) begin
        fresh <= (fill_count != '0) && in_win_fresh;
        issue_active <= (fill_count != '0) && in_win_fresh;
        issue_idx <= '0;
        sum <= '0;
        cnt <= '0;
        data_vld <= 1'b0;
        graph_done_r <= 1'b0;
      end else if (cmd.scan_step || cmd.emit_graph) begin
        if (issue_active && !scan_stall) begin
          data_vld <= 1'b1;
          issue_active <= (issue_idx + CntW'(1) != fill_count) && !graph_fin;
          issue_idx <= issue_idx + CntW'(1);
        end else if (!scan_stall) begin
          data_vld <= 1'b0;
        end
        if (cmd.scan_step && data_vld && in_win_scan) begin
          sum <= sum + SumW'(item.field_select ? rd_second : rd_first);
          cnt <= cnt + CntW'(1);
        end
      end
      if (cmd.graph_setup) begin
        limit <= elig_lim;
        skip <= cnt - elig_lim;
        emitted <= '0;
        issue_idx <= '0;
        issue_active <= 1'b1;
        data_vld <= 1'b0;
      end
      if (graph_take) begin
        if (skip != '0) begin
          skip <= skip - CntW'(1);
        end else begin
          emitted <= emitted + CntW'(1);
          if (graph_fin) graph_done_r <= 1'b1;
        end
      end
      if (cmd.div_start) begin
        div_busy <= (cnt != '0);
        div_rem <= '0;
        div_quo <= sum;
        div_steps <= '0;
      end else if (div_busy) begin
        if (!div_trial[SumW]) begin
          div_rem <= div_trial[SumW-1:0];
          div_quo <= {div_quo[SumW-2:0], 1'b1};
        end else begin
          div_rem <= {div_rem[SumW-2:0], div_quo[SumW-1]};
          div_quo <= {div_quo[SumW-2:0], 1'b0};
        end
        div_steps <= div_steps + 1'b1;
        if (div_steps == ($clog2(SumW+1))'(SumW - 1)) div_busy <= 1'b0;
      end
    end
  end

  // Next result: the single result of add, reset, average and an empty graph readout, or one graph entry.
  always_comb begin
    out_next = '0;
    out_next.last = 1'b1;
    out_next.accepted = accepted_flag;
    if (item.func == FuncAvg) begin
      out_next.sample_count = GmaxW'(cnt);
      out_next.mean_value = (cnt != '0) ? ValW'(div_quo) : '0;
    end
    if (graph_emit) begin
      out_next = '0;
      out_next.sample_count = GmaxW'(limit);
      out_next.graph_value = rd_first;
      out_next.item_valid = 1'b1;
      out_next.last = (emitted + CntW'(1) == limit);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_simple || graph_emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_simple || graph_emit) out_data <= out_next;
  end

  always_comb begin
    stat.func = item.func;
    stat.scan_done = !issue_active && !data_vld;
    stat.div_done = !div_busy;
    stat.graph_empty = !fresh || (item.graph_max == '0) || (elig_lim == '0);
    stat.graph_done = graph_done_r;
    stat.out_busy = out_busy;
  end

endmodule

// ===== rtl/timed_sample_ring_window_average_top.sv =====
// Top level of the timed sample ring with windowed average and graph readout.
// Add and reset: the item passes the decode and emit states, and the result is registered
// once the result register is free. Queries read the ring through one registered memory
// port, one entry a cycle while no graph result waits. An average scans the ring and then
// runs a 36-step restoring divide; a graph readout walks the ring twice. The controller
// takes one item at a time. Reset is synchronous and empties the ring.
module timed_sample_ring_window_average_top import tsrwa_pkg::*; (
  input logic clk,
  input logic rst,
  tsrwa_if.sink   in_ch,
  tsrwa_if.source out_ch
);

  cmd_t cmd;
  stat_t stat;

  // The controller admits one item at a time and sequences the datapath.
  tsrwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the sample memories and the single result register.
  tsrwa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item_in   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the timed sample ring: scoreboard class, stimulus tasks and checks.
module tb_top;
  import tsrwa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tsrwa_if #(.payload_t(item_t))   in_ch  (clk);
  tsrwa_if #(.payload_t(result_t)) out_ch (clk);

  timed_sample_ring_window_average_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // The scoreboard keeps its own ring and turns every accepted transfer into
  // the results the block should give, which wait in a queue until they come.
  class ring_scoreboard;
    logic [TimeW-1:0] stamps [Depth];
    logic [ValW-1:0]  firsts [Depth];
    logic [ValW-1:0]  seconds [Depth];
    int unsigned      wr_ptr;
    int unsigned      fill;
    logic [SeqW-1:0]  floor_seq;
    result_t          pending [$];
    int               mismatches;

    function new();
      wr_ptr = 0;
      fill = 0;
      floor_seq = '0;
      mismatches = 0;
    endfunction

    function bit aged_in(logic [TimeW-1:0] now, logic [TimeW-1:0] at, logic [TimeW:0] win);
      return at != 0 && at <= now && ({1'b0, now - at} <= win);
    endfunction

    function int unsigned slot(int unsigned i);
      return (wr_ptr + Depth - fill + i) % Depth;
    endfunction

    function bit is_fresh(logic [TimeW-1:0] now);
      return fill != 0 && aged_in(now, stamps[slot(fill - 1)], {1'b0, FreshMs});
    endfunction

    function void push_plain(bit acc, logic [GmaxW-1:0] cnt, logic [ValW-1:0] mean);
      result_t r;
      r = '0;
      r.accepted = acc;
      r.sample_count = cnt;
      r.mean_value = mean;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_item(item_t it);
      logic [63:0] sum;
      int unsigned cnt, eligible, limit, skip, n, s;
      result_t r;
      case (it.func)
        FuncAdd: begin
          if (it.sequence_req <= floor_seq) begin
            push_plain(1'b0, '0, '0);
          end else begin
            stamps[wr_ptr] = it.time_ms;
            firsts[wr_ptr] = it.value_a;
            seconds[wr_ptr] = it.value_b;
            wr_ptr = (wr_ptr + 1) % Depth;
            if (fill < Depth) fill++;
            floor_seq = it.sequence_req;
            push_plain(1'b1, '0, '0);
          end
        end
        FuncReset: begin
          fill = 0;
          wr_ptr = 0;
          if (it.sequence_req > floor_seq) floor_seq = it.sequence_req;
          push_plain(1'b0, '0, '0);
        end
        FuncAvg: begin
          sum = 0;
          cnt = 0;
          if (is_fresh(it.time_ms)) begin
            for (int unsigned i = 0; i < fill; i++) begin
              s = slot(i);
              if (aged_in(it.time_ms, stamps[s], {17'd0, it.window_ms})) begin
                sum += it.field_select ? seconds[s] : firsts[s];
                cnt++;
              end
            end
          end
          push_plain(1'b0, GmaxW'(cnt), (cnt != 0) ? ValW'(sum / cnt) : '0);
        end
        default: begin
          eligible = 0;
          if (it.graph_max != 0 && is_fresh(it.time_ms)) begin
            for (int unsigned i = 0; i < fill; i++)
              if (aged_in(it.time_ms, stamps[slot(i)], {1'b0, GraphMs})) eligible++;
          end
          limit = (eligible < it.graph_max) ? eligible : it.graph_max;
          if (limit > MaxOut) limit = MaxOut;
          if (limit == 0) begin
            push_plain(1'b0, '0, '0);
          end else begin
            skip = eligible - limit;
            n = 0;
            for (int unsigned i = 0; i < fill && n < limit; i++) begin
              s = slot(i);
              if (aged_in(it.time_ms, stamps[s], {1'b0, GraphMs})) begin
                if (skip != 0) begin
                  skip--;
                end else begin
                  r = '0;
                  r.sample_count = GmaxW'(limit);
                  r.graph_value = firsts[s];
                  r.item_valid = 1'b1;
                  r.last = (n + 1 == limit);
                  pending.push_back(r);
                  n++;
                end
              end
            end
          end
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result mismatch, expected %p, got %p", want, got);
      end
    endfunction
  endclass

  ring_scoreboard sb;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned burst_left;
  logic [31:0] seq_next;
  logic [TimeW-1:0] clock_ms;

  // Start the run with every input at a known value.
  initial begin
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // The receiver stalls on its own pattern: long ready stretches, then random drops.
  always @(negedge clk) begin
    if ((results_seen / 50) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Results are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.data);
      results_seen++;
    end
  end

  // Present one item and hold it until the block takes it. Between bursts the
  // sender idles for a random number of cycles.
  task automatic send_item(item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Build an item with random noise in every field, then set the fields that matter.
  function automatic item_t noise_item();
    item_t it;
    it.func = 2'($urandom);
    it.sequence_req = $urandom;
    it.time_ms = {16'($urandom), 32'($urandom)};
    it.value_a = 28'($urandom);
    it.value_b = 28'($urandom);
    it.field_select = 1'($urandom);
    it.window_ms = $urandom;
    it.graph_max = 8'($urandom);
    return it;
  endfunction

  function automatic item_t make_add(logic [31:0] sq, logic [TimeW-1:0] t);
    item_t it;
    it = noise_item();
    it.func = FuncAdd;
    it.sequence_req = sq;
    it.time_ms = t;
    it.value_a = ($urandom_range(0, 9) == 0) ? 28'($urandom) : 28'($urandom_range(0, 153600000));
    it.value_b = ($urandom_range(0, 9) == 0) ? 28'($urandom) : 28'($urandom_range(0, 153600000));
    return it;
  endfunction

  function automatic item_t make_query(logic [1:0] f, logic [TimeW-1:0] t);
    item_t it;
    it = noise_item();
    it.func = f;
    it.time_ms = t;
    case ($urandom_range(0, 3))
      0: it.window_ms = $urandom_range(0, 3000);
      1: it.window_ms = $urandom_range(0, 200);
      2: it.window_ms = 32'hFFFF_FFFF;
      default: it.window_ms = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: it.graph_max = 8'($urandom_range(0, 8));
      1: it.graph_max = 8'($urandom_range(60, 130));
      default: it.graph_max = 8'($urandom);
    endcase
    return it;
  endfunction

  item_t it;
  int unsigned waited;

  initial begin
    results_seen = 0;
    items_sent = 0;
    burst_left = 0;
    seq_next = 32'd1;
    clock_ms = 48'd5000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: queries on an empty ring, stale adds, zero stamps, value
    // extremes, resets that keep the floor, graph limits and stale rings.
    send_item(make_query(FuncAvg, 48'd100));
    send_item(make_query(FuncGraph, 48'd100));
    it = make_add(32'd0, 48'd10);
    send_item(it);                                   // sequence equal to floor: dropped
    it = make_add(32'd5, 48'd0); send_item(it);      // zero stamp is never inside
    it = make_add(32'd6, 48'd1000);
    it.value_a = 28'hFFF_FFFF; it.value_b = '0; send_item(it);
    it = make_add(32'd7, 48'd1500);
    it.value_a = '0; it.value_b = 28'd153600000; send_item(it);
    it = make_add(32'd7, 48'd1600); send_item(it);   // repeated sequence: dropped
    it = make_query(FuncAvg, 48'd1500); it.window_ms = '0; it.field_select = 1'b0; send_item(it);
    it = make_query(FuncAvg, 48'd2000); it.window_ms = '1; it.field_select = 1'b1; send_item(it);
    it = make_query(FuncAvg, 48'd900); send_item(it);   // newest lies in the future
    it = make_query(FuncAvg, 48'd3500); send_item(it);  // newest exactly at the 2000 limit
    it = make_query(FuncAvg, 48'd3501); send_item(it);  // ring just gone stale
    it = make_query(FuncGraph, 48'd2000); it.graph_max = 0; send_item(it);
    it = make_query(FuncGraph, 48'd2000); it.graph_max = 1; send_item(it);
    it = make_query(FuncGraph, 48'd2000); it.graph_max = 8'hFF; send_item(it);
    it = noise_item(); it.func = FuncReset; it.sequence_req = 32'd3; send_item(it);
    it = make_add(32'd8, 48'hFFFF_FFFF_FFFF); send_item(it);
    it = make_query(FuncAvg, 48'hFFFF_FFFF_FFFF); send_item(it);
    it = noise_item(); it.func = FuncReset; it.sequence_req = 32'd0; send_item(it);

    // Fill past the ring depth so the oldest entries get overwritten, then read
    // the full ring back with the widest window and the largest graph limits.
    seq_next = 32'd8;
    for (int k = 0; k < 150; k++) begin
      clock_ms += 10;
      seq_next += 1;
      send_item(make_add(seq_next, clock_ms));
    end
    it = make_query(FuncAvg, clock_ms + 5); it.window_ms = '1; send_item(it);
    it = make_query(FuncGraph, clock_ms + 5); it.graph_max = 8'd128; send_item(it);
    it = make_query(FuncGraph, clock_ms + 5); it.graph_max = 8'd100; send_item(it);

    // Random part. Sequences keep rising so most adds land; resets and noise
    // items only raise the floor a little above the running sequence.
    for (int k = 0; k < 250; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = noise_item();
        it.sequence_req = $urandom_range(0, seq_next + 2);
        send_item(it);
      end else begin
        clock_ms += $urandom_range(0, 400);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            seq_next += $urandom_range(1, 4);
            send_item(make_add(seq_next, clock_ms));
          end
          9: send_item(make_add($urandom_range(0, seq_next), clock_ms));
          10, 11, 12, 13: send_item(make_query(FuncAvg, clock_ms + $urandom_range(0, 2500)));
          14, 15, 16, 17: send_item(make_query(FuncGraph, clock_ms + $urandom_range(0, 12000)));
          default: begin
            it = noise_item(); it.func = FuncReset;
            it.sequence_req = $urandom_range(0, seq_next + 2);
            send_item(it);
          end
        endcase
      end
    end

    // The floor driven to its top value by a reset and the last add; nothing can be stored after that.
    it = noise_item(); it.func = FuncReset; it.sequence_req = 32'hFFFF_FFFE; send_item(it);
    it = make_add(32'hFFFF_FFFE, 48'd10); send_item(it);
    it = make_add(32'hFFFF_FFFF, 48'd20); send_item(it);
    it = make_query(FuncGraph, 48'd20); send_item(it);
    it = noise_item(); it.func = FuncReset; it.sequence_req = 32'd0; send_item(it);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    $display("Run covered %0d input transfers and %0d result transfers.", items_sent,
             results_seen);
    $display("Adds, resets, windowed averages and graph readouts with random idling.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on a generous fixed time.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== timed_sample_ring_window_average_top.f =====
rtl/tsrwa_pkg.sv
rtl/tsrwa_if.sv
rtl/tsrwa_ctrl.sv
rtl/tsrwa_dp.sv
rtl/timed_sample_ring_window_average_top.sv
verif/tb_top.sv
